// File: src/asss_pkg.sv
// ----------------------------------------------------------------------------
// asss_pkg
// Shared types, constants and helpers of the active set slip solver.
// ----------------------------------------------------------------------------
package asss_pkg;

  // number format and index widths
  localparam int QW    = 48;
  localparam int IDX_W = 5;
  localparam int COL_W = 6;
  localparam int CFG_W = 6;

  // augmented column holds the right-hand side and the solution
  localparam logic [COL_W-1:0] AUG_COL = 6'd32;

  localparam logic [QW-1:0] Q_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [QW-1:0] Q_MIN = 48'h8000_0000_0000;

  // input item kinds
  localparam logic [1:0] ACT_MAT   = 2'd0;
  localparam logic [1:0] ACT_VEC   = 2'd1;
  localparam logic [1:0] ACT_CAND  = 2'd2;
  localparam logic [1:0] ACT_SOLVE = 2'd3;

  // shared unit operations
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic          start;
    logic          op;
    logic [QW-1:0] a;
    logic [QW-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] res;
  } arith_rsp_t;

  typedef struct packed {
    logic             last;
    logic             singular;
    logic [QW-2:0]    amount;
    logic [IDX_W-1:0] pos;
    logic             active;
    logic [IDX_W-1:0] sys_idx;
  } res_t;

  // magnitude of a two's complement value
  function automatic logic [QW-1:0] mag(input logic [QW-1:0] v);
    mag = v[QW-1] ? (~v + 1'b1) : v;
  endfunction

  // saturating difference
  function automatic logic [QW-1:0] sat_sub(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [QW:0] d;
    d = {a[QW-1], a} - {b[QW-1], b};
    if (d[QW] != d[QW-1]) sat_sub = d[QW] ? Q_MIN : Q_MAX;
    else sat_sub = d[QW-1:0];
  endfunction

endpackage

// File: src/asss_arith.sv
// ----------------------------------------------------------------------------
// asss_arith
// Shared bit-serial fixed point multiplier and divider, one bit per cycle.
// ----------------------------------------------------------------------------
module asss_arith #(
  parameter int FRACTION_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  asss_pkg::arith_req_t req,
  output asss_pkg::arith_rsp_t rsp
);

  localparam int QW    = asss_pkg::QW;
  localparam int NUM_W = QW + FRACTION_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, done_r, op_r, neg_r, zero_r, over_r;
  logic [CNT_W-1:0] cnt_r;
  logic [QW-1:0]    ub_r, hi_r, lo_r, rem_r;
  logic [NUM_W-1:0] num_r;
  logic [QW-2:0]    q_r;
  logic [QW:0]      sum, rs;
  logic [2*QW-1:0]  prod;
  logic [QW-2:0]    m;
  logic [QW-1:0]    ua, ub;

  assign ua = asss_pkg::mag(req.a);
  assign ub = asss_pkg::mag(req.b);

  // one step of each datapath
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, ub_r} : '0);
  assign rs  = {rem_r, num_r[NUM_W-1]};

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        neg_r  <= req.a[QW-1] ^ req.b[QW-1];
        ub_r   <= ub;
        zero_r <= (ub == '0);
        hi_r   <= '0;
        lo_r   <= ua;
        num_r  <= {ua, {FRACTION_BITS{1'b0}}};
        rem_r  <= '0;
        q_r    <= '0;
        over_r <= 1'b0;
        cnt_r  <= (req.op == asss_pkg::OP_MUL) ? CNT_W'(QW - 1) : CNT_W'(NUM_W - 1);
      end else if (busy_r) begin
        if (op_r == asss_pkg::OP_MUL) begin
          hi_r <= sum[QW:1];
          lo_r <= {sum[0], lo_r[QW-1:1]};
        end else begin
          num_r <= {num_r[NUM_W-2:0], 1'b0};
          if (rs >= {1'b0, ub_r}) begin
            rem_r <= QW'(rs - {1'b0, ub_r});
            q_r   <= {q_r[QW-3:0], 1'b1};
            if (cnt_r >= CNT_W'(QW - 1)) over_r <= 1'b1;
          end else begin
            rem_r <= rs[QW-1:0];
            q_r   <= {q_r[QW-3:0], 1'b0};
          end
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // result scaling, saturation and sign
  assign prod = {hi_r, lo_r};

  always_comb begin
    if (op_r == asss_pkg::OP_MUL) begin
      m = (|prod[2*QW-1:QW-1+FRACTION_BITS]) ? asss_pkg::Q_MAX[QW-2:0]
                                              : prod[QW-2+FRACTION_BITS:FRACTION_BITS];
    end else begin
      m = over_r ? asss_pkg::Q_MAX[QW-2:0] : q_r;
    end
    rsp.done = done_r;
    if (op_r == asss_pkg::OP_DIV && zero_r) rsp.res = '0;
    else rsp.res = neg_r ? (~{1'b0, m} + 1'b1) : {1'b0, m};
  end

endmodule

// File: src/asss_ctrl.sv
// ----------------------------------------------------------------------------
// asss_ctrl
// Load storage, active set bookkeeping and the Gauss-Jordan sequencer.
// ----------------------------------------------------------------------------
module asss_ctrl #(
  parameter int MAX_SYSTEMS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             in_action,
  input  logic [asss_pkg::IDX_W-1:0]             in_row,
  input  logic [asss_pkg::IDX_W-1:0]             in_col,
  input  logic [asss_pkg::QW-1:0]                in_value,
  input  logic [asss_pkg::CFG_W-1:0]             n_cfg,
  output asss_pkg::arith_req_t                   areq,
  input  asss_pkg::arith_rsp_t                   arsp,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output asss_pkg::res_t                         res
);

  localparam int NMAX = (MAX_SYSTEMS < 32) ? MAX_SYSTEMS : 32;
  localparam int QW = asss_pkg::QW;
  localparam logic [5:0] AUG = asss_pkg::AUG_COL;

  localparam logic [4:0] S_IDLE = 5'd0,  S_BUILD = 5'd1,  S_COPY_ROW = 5'd2,
                         S_COPY_RD = 5'd3, S_COPY_WR = 5'd4, S_PIV_INIT = 5'd5,
                         S_PIV_RD = 5'd6, S_PIV_CMP = 5'd7, S_PIV_DONE = 5'd8,
                         S_SWP_RA = 5'd9, S_SWP_RB = 5'd10, S_SWP_WA = 5'd11,
                         S_SWP_WB = 5'd12, S_NRM_RD = 5'd13, S_NRM_GO = 5'd14,
                         S_NRM_WT = 5'd15, S_ELM_ROW = 5'd16, S_ELM_F = 5'd17,
                         S_ELM_RC = 5'd18, S_ELM_RR = 5'd19, S_ELM_CAP = 5'd20,
                         S_ELM_WT = 5'd21, S_CMP_RD = 5'd22, S_CMP_CK = 5'd23,
                         S_CMP_END = 5'd24, S_FIN = 5'd25, S_MAP = 5'd26,
                         S_OUT_PRE = 5'd27, S_OUT_RD = 5'd28, S_OUT_EM = 5'd29;

  logic [4:0]    state_r;
  logic [5:0]    i_r, j_r, r_r, c_r, k_r, nk_r, n_r, cnt_r;
  logic [4:0]    p_r, li_r;
  logic [QW-1:0] best_r, piv_r, f_r, ta_r, tb_r;
  logic          sing_r;
  logic [31:0]   marks_r, act_r;
  logic [4:0]    list_r [32];
  logic [4:0]    cand_r [32];
  logic [4:0]    pos_r  [32];

  // storage
  logic [QW-1:0] sys_mem [1024];
  logic [QW-1:0] rhs_mem [32];
  logic [QW-1:0] wk_mem  [2048];
  logic [QW-1:0] sys_q, rhs_q, wk_q;
  logic [9:0]    sys_a;
  logic [4:0]    rhs_a, lst_a, lst_q;
  logic [10:0]   wk_ra, wk_wa;
  logic          wk_we;
  logic [QW-1:0] wk_wd, wk_m;

  logic acc, ld_mat, ld_vec, last_j;
  logic [5:0] j_next, n_new;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign ld_mat   = acc && (in_action == asss_pkg::ACT_MAT) &&
                    (int'(in_row) < MAX_SYSTEMS) && (int'(in_col) < MAX_SYSTEMS);
  assign ld_vec   = acc && (in_action == asss_pkg::ACT_VEC) && (int'(in_row) < MAX_SYSTEMS);

  // column walk: from the start column (0 or c) to k-1, then the augmented column
  assign last_j = (j_r == AUG);
  assign j_next = (j_r == k_r - 6'd1) ? AUG : j_r + 6'd1;

  assign lst_a = (state_r == S_COPY_RD) ? j_r[4:0] : i_r[4:0];
  assign lst_q = list_r[lst_a];
  assign sys_a = {li_r, lst_q};
  assign rhs_a = li_r;
  assign wk_m  = asss_pkg::mag(wk_q);

  // clamped system count
  always_comb begin
    if (n_cfg == '0) n_new = 6'd1;
    else if (int'(n_cfg) > NMAX) n_new = 6'(NMAX);
    else n_new = n_cfg;
  end

  always_ff @(posedge clk) begin
    if (ld_mat) sys_mem[{in_row, in_col}] <= in_value;
    sys_q <= sys_mem[sys_a];
  end

  always_ff @(posedge clk) begin
    if (ld_vec) rhs_mem[in_row] <= in_value;
    rhs_q <= rhs_mem[rhs_a];
  end

  always_ff @(posedge clk) begin
    if (wk_we) wk_mem[wk_wa] <= wk_wd;
    wk_q <= wk_mem[wk_ra];
  end

  // work memory read address
  always_comb begin
    case (state_r)
      S_PIV_RD:  wk_ra = {r_r[4:0], c_r};
      S_SWP_RA:  wk_ra = {p_r, j_r};
      S_SWP_RB:  wk_ra = {c_r[4:0], j_r};
      S_NRM_RD:  wk_ra = {c_r[4:0], j_r};
      S_ELM_ROW: wk_ra = {r_r[4:0], c_r};
      S_ELM_RC:  wk_ra = {c_r[4:0], j_r};
      S_CMP_RD:  wk_ra = {i_r[4:0], AUG};
      // keep the amount steady while the result item waits
      S_OUT_RD, S_OUT_EM: wk_ra = {pos_r[i_r[4:0]], AUG};
      default:   wk_ra = {r_r[4:0], j_r};
    endcase
  end

  // work memory write port and shared unit request
  always_comb begin
    wk_we = 1'b0;
    wk_wa = {r_r[4:0], j_r};
    wk_wd = '0;
    areq.start = 1'b0;
    areq.op = asss_pkg::OP_MUL;
    areq.a = f_r;
    areq.b = wk_q;
    case (state_r)
      S_COPY_WR: begin
        wk_we = 1'b1;
        wk_wa = {i_r[4:0], j_r};
        wk_wd = last_j ? rhs_q : sys_q;
      end
      S_SWP_WA: begin
        wk_we = 1'b1;
        wk_wa = {p_r, j_r};
        wk_wd = wk_q;
      end
      S_SWP_WB: begin
        wk_we = 1'b1;
        wk_wa = {c_r[4:0], j_r};
        wk_wd = ta_r;
      end
      S_NRM_GO: begin
        areq.start = 1'b1;
        areq.op = asss_pkg::OP_DIV;
        areq.a = wk_q;
        areq.b = piv_r;
      end
      S_NRM_WT: begin
        wk_we = arsp.done;
        wk_wa = {c_r[4:0], j_r};
        wk_wd = arsp.res;
      end
      S_ELM_RR: begin
        areq.start = 1'b1;
      end
      S_ELM_WT: begin
        wk_we = arsp.done;
        wk_wd = asss_pkg::sat_sub(tb_r, arsp.res);
      end
      default: begin
        wk_we = 1'b0;
      end
    endcase
  end

  // result item
  always_comb begin
    res_valid       = (state_r == S_OUT_EM);
    res.sys_idx     = i_r[4:0];
    res.active      = act_r[i_r[4:0]];
    res.pos         = act_r[i_r[4:0]] ? pos_r[i_r[4:0]] : 5'd0;
    res.amount      = (act_r[i_r[4:0]] && !sing_r && !wk_q[QW-1]) ? wk_q[QW-2:0] : '0;
    res.singular    = sing_r;
    res.last        = (i_r + 6'd1 == n_r);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      marks_r <= '0;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (acc && in_action == asss_pkg::ACT_CAND) begin
            if ((int'(in_row) < MAX_SYSTEMS) && !marks_r[in_row] && (int'(cnt_r) < NMAX)) begin
              marks_r[in_row]   <= 1'b1;
              cand_r[cnt_r[4:0]] <= in_row;
              cnt_r             <= cnt_r + 6'd1;
            end
          end else if (acc && in_action == asss_pkg::ACT_SOLVE) begin
            n_r     <= n_new;
            i_r     <= '0;
            k_r     <= '0;
            sing_r  <= 1'b0;
            state_r <= S_BUILD;
          end
        end
        S_BUILD: begin
          if (i_r == cnt_r) begin
            i_r     <= '0;
            state_r <= (k_r == '0) ? S_FIN : S_COPY_ROW;
          end else begin
            if ({1'b0, cand_r[i_r[4:0]]} < n_r) begin
              list_r[k_r[4:0]] <= cand_r[i_r[4:0]];
              k_r <= k_r + 6'd1;
            end
            i_r <= i_r + 6'd1;
          end
        end
        S_COPY_ROW: begin
          li_r    <= lst_q;
          j_r     <= '0;
          state_r <= S_COPY_RD;
        end
        S_COPY_RD: state_r <= S_COPY_WR;
        S_COPY_WR: begin
          if (last_j) begin
            if (i_r + 6'd1 == k_r) begin
              c_r     <= '0;
              state_r <= S_PIV_INIT;
            end else begin
              i_r     <= i_r + 6'd1;
              state_r <= S_COPY_ROW;
            end
          end else begin
            j_r     <= j_next;
            state_r <= S_COPY_RD;
          end
        end
        S_PIV_INIT: begin
          r_r     <= c_r;
          p_r     <= c_r[4:0];
          best_r  <= '0;
          state_r <= S_PIV_RD;
        end
        S_PIV_RD: state_r <= S_PIV_CMP;
        S_PIV_CMP: begin
          if (wk_m > best_r) begin
            best_r <= wk_m;
            p_r    <= r_r[4:0];
            piv_r  <= wk_q;
          end
          r_r     <= r_r + 6'd1;
          state_r <= (r_r + 6'd1 == k_r) ? S_PIV_DONE : S_PIV_RD;
        end
        S_PIV_DONE: begin
          if (best_r == '0) begin
            sing_r  <= 1'b1;
            state_r <= S_FIN;
          end else if (p_r != c_r[4:0]) begin
            j_r     <= '0;
            state_r <= S_SWP_RA;
          end else begin
            j_r     <= c_r;
            state_r <= S_NRM_RD;
          end
        end
        S_SWP_RA: state_r <= S_SWP_RB;
        S_SWP_RB: begin
          ta_r    <= wk_q;
          state_r <= S_SWP_WA;
        end
        S_SWP_WA: state_r <= S_SWP_WB;
        S_SWP_WB: begin
          if (last_j) begin
            j_r     <= c_r;
            state_r <= S_NRM_RD;
          end else begin
            j_r     <= j_next;
            state_r <= S_SWP_RA;
          end
        end
        S_NRM_RD: state_r <= S_NRM_GO;
        S_NRM_GO: state_r <= S_NRM_WT;
        S_NRM_WT: begin
          if (arsp.done) begin
            if (last_j) begin
              r_r     <= '0;
              state_r <= S_ELM_ROW;
            end else begin
              j_r     <= j_next;
              state_r <= S_NRM_RD;
            end
          end
        end
        S_ELM_ROW: begin
          if (r_r == k_r) begin
            if (c_r + 6'd1 == k_r) begin
              i_r     <= '0;
              nk_r    <= '0;
              state_r <= S_CMP_RD;
            end else begin
              c_r     <= c_r + 6'd1;
              state_r <= S_PIV_INIT;
            end
          end else if (r_r == c_r) begin
            r_r <= r_r + 6'd1;
          end else begin
            state_r <= S_ELM_F;
          end
        end
        S_ELM_F: begin
          f_r <= wk_q;
          if (wk_q == '0) begin
            r_r     <= r_r + 6'd1;
            state_r <= S_ELM_ROW;
          end else begin
            j_r     <= c_r;
            state_r <= S_ELM_RC;
          end
        end
        S_ELM_RC:  state_r <= S_ELM_RR;
        S_ELM_RR:  state_r <= S_ELM_CAP;
        S_ELM_CAP: begin
          tb_r    <= wk_q;
          state_r <= S_ELM_WT;
        end
        S_ELM_WT: begin
          if (arsp.done) begin
            if (last_j) begin
              r_r     <= r_r + 6'd1;
              state_r <= S_ELM_ROW;
            end else begin
              j_r     <= j_next;
              state_r <= S_ELM_RC;
            end
          end
        end
        S_CMP_RD: state_r <= S_CMP_CK;
        S_CMP_CK: begin
          // keep systems whose amount is not negative, in order
          if (!wk_q[QW-1]) begin
            list_r[nk_r[4:0]] <= lst_q;
            nk_r <= nk_r + 6'd1;
          end
          if (i_r + 6'd1 == k_r) begin
            state_r <= S_CMP_END;
          end else begin
            i_r     <= i_r + 6'd1;
            state_r <= S_CMP_RD;
          end
        end
        S_CMP_END: begin
          if (nk_r == k_r) begin
            state_r <= S_FIN;
          end else begin
            k_r     <= nk_r;
            i_r     <= '0;
            state_r <= (nk_r == '0) ? S_FIN : S_COPY_ROW;
          end
        end
        S_FIN: begin
          act_r   <= '0;
          i_r     <= '0;
          state_r <= (k_r == '0) ? S_OUT_PRE : S_MAP;
        end
        S_MAP: begin
          act_r[lst_q] <= 1'b1;
          pos_r[lst_q] <= i_r[4:0];
          if (i_r + 6'd1 == k_r) state_r <= S_OUT_PRE;
          else i_r <= i_r + 6'd1;
        end
        S_OUT_PRE: begin
          i_r     <= '0;
          state_r <= S_OUT_RD;
        end
        S_OUT_RD: state_r <= S_OUT_EM;
        S_OUT_EM: begin
          if (res_ready) begin
            if (i_r + 6'd1 == n_r) begin
              marks_r <= '0;
              cnt_r   <= '0;
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 6'd1;
              state_r <= S_OUT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/active_set_slip_solver_core.sv
// ----------------------------------------------------------------------------
// active_set_slip_solver_core
// Non-negative active set linear solve over loaded slip systems.
//
// channel  | direction | payload
// in_      | slave     | tuser: action; tdata: row_index, col_index, value
// out_     | master    | tdata: system_index .. singular; tlast: last
// cfg_     | write     | systems_in_use
//
// loads and candidate adds are taken while the solver is idle.
// a solve runs an elimination pass, and one more after each shrink of the active
// set; each pass uses the shared bit-serial multiply/divide unit for every
// multiply and subtract and every divide. then the n result items are emitted.
// in_tready is low for the whole solve.
// reset clears the candidate marks and control state; no clearing pass.
// out_ holds an item in a register until taken.
// ----------------------------------------------------------------------------
module active_set_slip_solver_core #(
  parameter int MAX_SYSTEMS   = 32,
  parameter int FRACTION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // action
  input  logic [63:0] in_tdata,   // row_index[4:0], col_index[9:5], value[57:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // system_index, is_active, active_position,
                                  // slip_amount, singular
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data
);

  asss_pkg::arith_req_t areq;
  asss_pkg::arith_rsp_t arsp;
  asss_pkg::res_t       res, out_r;
  logic                 res_valid, res_ready, out_valid_r;
  logic [5:0]           cfg_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= 6'd32;
    else if (cfg_wr_en) cfg_r <= cfg_wr_data;
  end

  asss_ctrl #(.MAX_SYSTEMS(MAX_SYSTEMS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .in_row    (in_tdata[4:0]),
    .in_col    (in_tdata[9:5]),
    .in_value  (in_tdata[57:10]),
    .n_cfg     (cfg_r),
    .areq      (areq),
    .arsp      (arsp),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  asss_arith #(.FRACTION_BITS(FRACTION_BITS)) u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .rsp   (arsp)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {5'd0, out_r.singular, out_r.amount, out_r.pos, out_r.active,
                       out_r.sys_idx};

endmodule

// File: bench/tb_active_set_slip_solver_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_active_set_slip_solver_core
// Self-checking bench for the active set slip solver. A queued driver loads
// small matrix systems, candidate lists and solve starts with random idle
// bursts. A fixed point predictor of the non-negative active set solve is
// updated on every accepted item. A monitor compares each result item
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_active_set_slip_solver_core;

  localparam int     FB       = 24;
  localparam longint QMAXL    = 64'sh7FFF_FFFF_FFFF;
  localparam longint QMINL    = -QMAXL - 1;
  localparam longint ONE      = 64'sd1 << FB;
  localparam int     WD_LIMIT = 400000;
  localparam int     HOLD_LEN = 3000;
  localparam int     N_ITEMS  = 380;

  typedef struct {
    logic [1:0]  act;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [47:0] val;
  } slip_item_t;

  typedef struct {
    logic [4:0]  sys;
    logic        act;
    logic [4:0]  pos;
    logic [46:0] amt;
    logic        sing;
    logic        lst;
  } slip_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [5:0]  cfg_wr_data = '0;

  active_set_slip_solver_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // predictor state
  longint     mat_q[32][32];
  longint     rhs_q[32];
  longint     wk[32][32];
  longint     amt_x[32];
  int         act_list[32];
  int         act_k;
  logic [4:0] cand_list[32];
  int         cand_n = 0;
  bit         cand_mark[32];
  logic [5:0] sys_cfg = 6'd32;

  slip_item_t pend_q[$];
  slip_res_t  slip_exp_q[$];
  slip_item_t cur;

  int  n_sent = 0;
  int  n_bad = 0;
  int  snd_gap = 0;
  int  rcv_gap = 0;
  int  hold_left = HOLD_LEN;
  int  wd_cnt = 0;
  bit  quiet = 0;
  bit  hold_go = 0;
  logic nv;
  logic rdy;

  // ---------------- fixed point arithmetic ----------------
  function automatic logic [47:0] q_abs(input longint a);
    logic [63:0] t;
    t = (a < 0) ? -a : a;
    return t[47:0];
  endfunction

  function automatic longint q_signed(input logic [95:0] m, input bit neg);
    longint r;
    if (m > 96'h7FFF_FFFF_FFFF) r = QMAXL;
    else r = longint'({16'd0, m[47:0]});
    return neg ? -r : r;
  endfunction

  function automatic longint q_mul(input longint a, input longint b);
    logic [95:0] p;
    p = {48'd0, q_abs(a)} * {48'd0, q_abs(b)};
    return q_signed(p >> FB, (a < 0) != (b < 0));
  endfunction

  function automatic longint q_div(input longint a, input longint b);
    logic [95:0] num;
    if (q_abs(b) == 0) return 0;
    num = {24'd0, q_abs(a), 24'd0};
    return q_signed(num / {48'd0, q_abs(b)}, (a < 0) != (b < 0));
  endfunction

  function automatic longint q_sub(input longint a, input longint b);
    longint d;
    d = a - b;
    if (d > QMAXL) return QMAXL;
    if (d < QMINL) return QMINL;
    return d;
  endfunction

  // gauss-jordan with partial pivoting over act_list; 0 on a zero pivot
  function automatic bit eliminate();
    int         p;
    longint     piv, t, f;
    logic [47:0] best, m;
    for (int i = 0; i < act_k; i++) begin
      amt_x[i] = rhs_q[act_list[i]];
      for (int j = 0; j < act_k; j++) wk[i][j] = mat_q[act_list[i]][act_list[j]];
    end
    for (int c = 0; c < act_k; c++) begin
      p = c;
      best = q_abs(wk[c][c]);
      for (int r = c + 1; r < act_k; r++) begin
        m = q_abs(wk[r][c]);
        if (m > best) begin
          best = m;
          p = r;
        end
      end
      if (best == 0) return 0;
      if (p != c) begin
        for (int j = 0; j < act_k; j++) begin
          t = wk[p][j]; wk[p][j] = wk[c][j]; wk[c][j] = t;
        end
        t = amt_x[p]; amt_x[p] = amt_x[c]; amt_x[c] = t;
      end
      piv = wk[c][c];
      for (int j = c; j < act_k; j++) wk[c][j] = q_div(wk[c][j], piv);
      amt_x[c] = q_div(amt_x[c], piv);
      for (int r = 0; r < act_k; r++) begin
        if (r != c && wk[r][c] != 0) begin
          f = wk[r][c];
          for (int j = c; j < act_k; j++) wk[r][j] = q_sub(wk[r][j], q_mul(f, wk[c][j]));
          amt_x[r] = q_sub(amt_x[r], q_mul(f, amt_x[c]));
        end
      end
    end
    return 1;
  endfunction

  // active set iteration and result prediction
  task automatic predict_solve();
    int        n, nk, pos;
    bit        sing, found;
    slip_res_t r;
    n = sys_cfg;
    if (n > 32) n = 32;
    if (n == 0) n = 1;
    act_k = 0;
    sing = 0;
    for (int i = 0; i < cand_n; i++)
      if (cand_list[i] < n) act_list[act_k++] = cand_list[i];
    while (act_k > 0) begin
      if (!eliminate()) begin
        sing = 1;
        for (int i = 0; i < act_k; i++) amt_x[i] = 0;
        break;
      end
      nk = 0;
      for (int i = 0; i < act_k; i++)
        if (amt_x[i] >= 0) begin
          act_list[nk] = act_list[i];
          amt_x[nk] = amt_x[i];
          nk++;
        end
      if (nk == act_k) break;
      act_k = nk;
    end
    for (int i = 0; i < n; i++) begin
      found = 0;
      pos = 0;
      for (int j = 0; j < act_k; j++)
        if (act_list[j] == i) begin
          found = 1;
          pos = j;
        end
      r.sys  = i[4:0];
      r.act  = found;
      r.pos  = pos[4:0];
      r.amt  = (found && amt_x[pos] > 0) ? amt_x[pos][46:0] : '0;
      r.sing = sing;
      r.lst  = (i == n - 1);
      slip_exp_q.push_back(r);
    end
    for (int i = 0; i < 32; i++) cand_mark[i] = 0;
    cand_n = 0;
  endtask

  task automatic apply_item(input slip_item_t it);
    case (it.act)
      asss_pkg::ACT_MAT: mat_q[it.row][it.col] = longint'($signed(it.val));
      asss_pkg::ACT_VEC: rhs_q[it.row] = longint'($signed(it.val));
      asss_pkg::ACT_CAND: begin
        if (!cand_mark[it.row] && cand_n < 32) begin
          cand_mark[it.row] = 1;
          cand_list[cand_n++] = it.row;
        end
      end
      default: predict_solve();
    endcase
  endtask

  // ---------------- stimulus helpers ----------------
  task automatic push_item(input logic [1:0] act, input int row, input int col,
                           input longint val);
    slip_item_t it;
    it.act = act;
    it.row = row[4:0];
    it.col = col[4:0];
    it.val = val[47:0];
    pend_q.push_back(it);
    n_sent++;
  endtask

  function automatic longint rnd_full();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return longint'($signed(r[47:0]));
  endfunction

  function automatic longint rnd_signed(input int int_bits);
    longint v;
    v = longint'($urandom_range(0, (1 << int_bits) - 1)) << FB;
    v = v + $urandom_range(0, 24'hFF_FFFF);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // loads a system over k distinct indexes, adds them as candidates and starts
  // style 0 well conditioned, 1 full range values, 2 one zero column
  task automatic queue_solve(input int k, input int style, input int lim);
    int     sel[32];
    int     t, s, zc;
    longint v;
    for (int i = 0; i < 32; i++) sel[i] = i;
    for (int i = 0; i < k; i++) begin
      s = $urandom_range(i, lim - 1);
      t = sel[i]; sel[i] = sel[s]; sel[s] = t;
    end
    zc = sel[$urandom_range(0, k - 1)];
    for (int i = 0; i < k; i++) begin
      for (int j = 0; j < k; j++) begin
        if (style == 1) v = rnd_full();
        else if (style == 2 && sel[j] == zc) v = 0;
        else if (i == j) v = (longint'($urandom_range(4, 12)) << FB) +
                             $urandom_range(0, 24'hFF_FFFF);
        else v = rnd_signed(1);
        push_item(asss_pkg::ACT_MAT, sel[i], sel[j], v);
      end
      push_item(asss_pkg::ACT_VEC, sel[i], $urandom_range(0, 31),
                style == 1 ? rnd_full() : rnd_signed(3));
    end
    // stray loads at random indexes are noise that the predictor also applies
    if ($urandom_range(0, 2) == 0)
      push_item(2'($urandom_range(0, 1)), $urandom_range(0, 31), $urandom_range(0, 31),
                rnd_full());
    for (int i = k - 1; i >= 0; i--) begin
      push_item(asss_pkg::ACT_CAND, sel[i], $urandom_range(0, 31), rnd_full());
      if ($urandom_range(0, 3) == 0)
        push_item(asss_pkg::ACT_CAND, sel[i], $urandom_range(0, 31), rnd_full());
    end
    push_item(asss_pkg::ACT_SOLVE, $urandom_range(0, 31), $urandom_range(0, 31), rnd_full());
  endtask

  // checked between edges so that the driver's updates have settled
  task automatic drain();
    while (pend_q.size() != 0 || in_tvalid || slip_exp_q.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [5:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    sys_cfg = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------- clock ----------------
  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------- input driver ----------------
  always @(posedge clk) begin
    if (rst_n) begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        apply_item(cur);
        nv = 1'b0;
      end
      if (!nv) begin
        if (snd_gap > 0) snd_gap--;
        else if (!quiet && $urandom_range(0, 15) == 0) snd_gap = $urandom_range(0, 9);
        else if (pend_q.size() != 0) begin
          cur = pend_q.pop_front();
          nv = 1'b1;
        end
      end
      in_tvalid <= nv;
      in_tuser  <= cur.act;
      in_tdata  <= {6'd0, cur.val, cur.col, cur.row};
    end
  end

  // ---------------- result receiver ----------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_go && hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap--;
        rdy = 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        rcv_gap = $urandom_range(0, 9);
        rdy = 1'b0;
      end else rdy = 1'b1;
      out_tready <= rdy;
    end
  end

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (slip_exp_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result item tdata=%h", out_tdata);
      end else begin
        slip_res_t e;
        e = slip_exp_q.pop_front();
        if (out_tdata[4:0] !== e.sys || out_tdata[5] !== e.act ||
            out_tdata[10:6] !== e.pos || out_tdata[57:11] !== e.amt ||
            out_tdata[58] !== e.sing || out_tdata[63:59] !== 5'd0 ||
            out_tlast !== e.lst) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("mismatch: exp sys=%0d act=%0b pos=%0d amt=%h sing=%0b last=%0b",
                     e.sys, e.act, e.pos, e.amt, e.sing, e.lst);
            $display("          got sys=%0d act=%0b pos=%0d amt=%h sing=%0b last=%0b",
                     out_tdata[4:0], out_tdata[5], out_tdata[10:6], out_tdata[57:11],
                     out_tdata[58], out_tlast);
          end
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) wd_cnt <= 0;
      else wd_cnt <= wd_cnt + 1;
      if (wd_cnt >= WD_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------- test sequence ----------------
  initial begin
    logic [5:0] cfg_vals[8];
    int         n_now, k, lim, phase;
    cfg_vals = '{6'd1, 6'd0, 6'd63, 6'd7, 6'd33, 6'd16, 6'd3, 6'd32};
    for (int i = 0; i < 32; i++) cand_mark[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_cfg(6'd32);

    // directed: full scale division, duplicate candidate
    push_item(asss_pkg::ACT_MAT, 0, 0, QMINL);
    push_item(asss_pkg::ACT_VEC, 0, 31, QMAXL);
    push_item(asss_pkg::ACT_CAND, 0, 0, 0);
    push_item(asss_pkg::ACT_CAND, 0, 0, 0);
    push_item(asss_pkg::ACT_SOLVE, 0, 0, 0);
    // empty active set
    push_item(asss_pkg::ACT_SOLVE, 31, 31, -1);
    // negative amount is dropped
    push_item(asss_pkg::ACT_MAT, 31, 31, ONE);
    push_item(asss_pkg::ACT_VEC, 31, 0, -ONE);
    push_item(asss_pkg::ACT_CAND, 31, 0, 0);
    push_item(asss_pkg::ACT_SOLVE, 0, 0, 0);
    // zero pivot
    queue_solve(2, 2, 32);
    drain();

    // random phases, the receiver holds off once in the third one
    phase = 0;
    while (n_sent < N_ITEMS) begin
      write_cfg(phase < 8 ? cfg_vals[phase] : 6'($urandom_range(0, 63)));
      n_now = sys_cfg > 32 ? 32 : (sys_cfg == 0 ? 1 : sys_cfg);
      if (phase == 2) hold_go = 1;
      if (n_sent > N_ITEMS - 60) quiet = 1;
      for (int s = 0; s < 4; s++) begin
        lim = ($urandom_range(0, 3) == 0) ? 32 : n_now;
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
        if (k > lim) k = lim;
        case ($urandom_range(0, 9))
          0:       queue_solve(k, 1, lim);
          1:       queue_solve(k, 2, lim);
          default: queue_solve(k, 0, lim);
        endcase
      end
      drain();
      phase++;
    end

    if (n_bad == 0 && slip_exp_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
